// File: rtl/assert_macros.svh
// Assertion macros for the shortest-arc quaternion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every clock edge outside reset.
`define SARQ_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// Condition that must never be true outside reset.
`define SARQ_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);
`else
`define SARQ_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define SARQ_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif
`endif

// File: rtl/sarq_pkg.sv
// Shared constants, types and helper functions of the shortest-arc quaternion block.
package sarq_pkg;

	localparam int ROOT_STEPS = 32;
	localparam int QUO_BITS = 31;
	localparam int LIM_W = 31;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
	localparam logic [30:0] ONE_Q30_MAG = 31'h4000_0000;
	localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 31'd1074;

	typedef enum logic [1:0] {
		CASE_IDENTITY  = 2'd0,
		CASE_ARC       = 2'd1,
		CASE_FALLBACK  = 2'd2,
		CASE_GENERATED = 2'd3
	} case_t;

	// Smallest left shift that brings a nonzero magnitude up to at least 2^30.
	function automatic logic [4:0] norm_shift(input logic [31:0] m);
		logic [4:0] k;
		k = '0;
		for (int i = 0; i < 31; i++) begin
			if (m[i]) k = 5'(30 - i);
		end
		if (m[31]) k = '0;
		return k;
	endfunction

	function automatic logic signed [31:0] sat_q30(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > ONE_Q30) r = ONE_Q30;
		if (v < NEG_ONE_Q30) r = NEG_ONE_Q30;
		return r;
	endfunction

endpackage

// File: rtl/sarq_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
module sarq_isqrt import sarq_pkg::*; #(
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [LANES-1:0][63:0]  in_rad,
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	output logic [LANES-1:0][31:0]  out_root,
	output logic [SIDE_W-1:0]       out_side
);

	logic [LANES-1:0][63:0] rem_s [ROOT_STEPS];
	logic [LANES-1:0][63:0] root_s [ROOT_STEPS];
	logic [SIDE_W-1:0]      side_s [ROOT_STEPS];
	logic                   vld_s [ROOT_STEPS];

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [LANES-1:0][63:0] prv_rem, prv_root, nxt_rem, nxt_root;
		logic [SIDE_W-1:0]      prv_side;
		logic                   prv_vld;

		if (j == 0) begin : g_first
			assign prv_rem  = in_rad;
			assign prv_root = '0;
			assign prv_side = in_side;
			assign prv_vld  = in_valid;
		end else begin : g_next
			assign prv_rem  = rem_s[j-1];
			assign prv_root = root_s[j-1];
			assign prv_side = side_s[j-1];
			assign prv_vld  = vld_s[j-1];
		end

		always_comb begin
			logic [63:0] trial [LANES];
			for (int l = 0; l < LANES; l++) begin
				trial[l] = prv_root[l] + BIT;
				if (prv_rem[l] >= trial[l]) begin
					nxt_rem[l]  = prv_rem[l] - trial[l];
					nxt_root[l] = (prv_root[l] >> 1) + BIT;
				end else begin
					nxt_rem[l]  = prv_rem[l];
					nxt_root[l] = prv_root[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nxt_rem;
				root_s[j] <= nxt_root;
				side_s[j] <= prv_side;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_root[l] = root_s[ROOT_STEPS-1][l][31:0];
		end
	end

	assign out_valid = vld_s[ROOT_STEPS-1];
	assign out_side  = side_s[ROOT_STEPS-1];

endmodule

// File: rtl/sarq_div.sv
// Pipelined restoring divider: 31 quotient bits, one per stage, with an overflow flag.
module sarq_div import sarq_pkg::*; #(
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [LANES-1:0][63:0]          in_dividend,
	input  logic [LANES-1:0][31:0]          in_divisor,
	input  logic [SIDE_W-1:0]               in_side,
	output logic                            out_valid,
	output logic [LANES-1:0][QUO_BITS-1:0]  out_quot,
	output logic [LANES-1:0]                out_ovf,
	output logic [SIDE_W-1:0]               out_side
);

	logic [LANES-1:0][63:0]          rem_s [QUO_BITS];
	logic [LANES-1:0][31:0]          dvs_s [QUO_BITS];
	logic [LANES-1:0][QUO_BITS-1:0]  quot_s [QUO_BITS];
	logic [LANES-1:0]                ovf_s [QUO_BITS];
	logic [SIDE_W-1:0]               side_s [QUO_BITS];
	logic                            vld_s [QUO_BITS];

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
		localparam int SH = QUO_BITS - 1 - j;
		logic [LANES-1:0][63:0]          prv_rem, nxt_rem;
		logic [LANES-1:0][31:0]          prv_dvs;
		logic [LANES-1:0][QUO_BITS-1:0]  prv_quot, nxt_quot;
		logic [LANES-1:0]                prv_ovf;
		logic [SIDE_W-1:0]               prv_side;
		logic                            prv_vld;

		if (j == 0) begin : g_first
			// A quotient of 2^31 or more cannot be formed here; flag it instead.
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					prv_ovf[l] = in_dividend[l][63:31] >= {1'b0, in_divisor[l]};
				end
			end
			assign prv_rem  = in_dividend;
			assign prv_dvs  = in_divisor;
			assign prv_quot = '0;
			assign prv_side = in_side;
			assign prv_vld  = in_valid;
		end else begin : g_next
			assign prv_rem  = rem_s[j-1];
			assign prv_dvs  = dvs_s[j-1];
			assign prv_quot = quot_s[j-1];
			assign prv_ovf  = ovf_s[j-1];
			assign prv_side = side_s[j-1];
			assign prv_vld  = vld_s[j-1];
		end

		always_comb begin
			logic [63:0] trial [LANES];
			for (int l = 0; l < LANES; l++) begin
				trial[l]    = 64'(prv_dvs[l]) << SH;
				nxt_quot[l] = prv_quot[l];
				if (prv_rem[l] >= trial[l]) begin
					nxt_rem[l]      = prv_rem[l] - trial[l];
					nxt_quot[l][SH] = 1'b1;
				end else begin
					nxt_rem[l] = prv_rem[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nxt_rem;
				dvs_s[j]  <= prv_dvs;
				quot_s[j] <= nxt_quot;
				ovf_s[j]  <= prv_ovf;
				side_s[j] <= prv_side;
			end
		end
	end

	assign out_valid = vld_s[QUO_BITS-1];
	assign out_quot  = quot_s[QUO_BITS-1];
	assign out_ovf   = ovf_s[QUO_BITS-1];
	assign out_side  = side_s[QUO_BITS-1];

endmodule

// File: rtl/sarq_norm.sv
// Pipeline that normalizes three vectors to unit length in Q2.30.
module sarq_norm import sarq_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2:0][2:0][32:0]    in_vec,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [2:0][2:0][31:0]    out_vec,
	output logic [SIDE_W-1:0]        out_side
);

	localparam int RS_W = SIDE_W + 3 + 9 + 9 * 32;
	localparam int DS_W = SIDE_W + 3 + 9;

	logic [2:0][2:0][31:0] mag_s1, mag_s2, sh_s3, sh_s4, sh_s5;
	logic [2:0][2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2:0][2:0][63:0] sq_s4;
	logic [2:0][63:0]      len_s5;
	logic [2:0][4:0]       k_s2;
	logic [2:0]            zero_s2, zero_s3, zero_s4, zero_s5;
	logic [SIDE_W-1:0]     side_s1, side_s2, side_s3, side_s4, side_s5;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [2:0][31:0]      max_mag;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			max_mag[v] = mag_s1[v][0];
			if (mag_s1[v][1] > max_mag[v]) max_mag[v] = mag_s1[v][1];
			if (mag_s1[v][2] > max_mag[v]) max_mag[v] = mag_s1[v][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				for (int c = 0; c < 3; c++) begin
					mag_s1[v][c] <= in_vec[v][c][32] ? 32'(-in_vec[v][c]) : in_vec[v][c][31:0];
					neg_s1[v][c] <= in_vec[v][c][32];
					sh_s3[v][c]  <= mag_s2[v][c] << k_s2[v];
					sq_s4[v][c]  <= 64'(sh_s3[v][c]) * 64'(sh_s3[v][c]);
				end
				k_s2[v]    <= norm_shift(max_mag[v]);
				zero_s2[v] <= max_mag[v] == '0;
				len_s5[v]  <= sq_s4[v][0] + sq_s4[v][1] + sq_s4[v][2];
			end
			side_s1 <= in_side;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
			sh_s4   <= sh_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
			sh_s5   <= sh_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;
		end
	end

	logic                  rt_valid;
	logic [2:0][31:0]      rt_root;
	logic [RS_W-1:0]       rt_side_in, rt_side_out;
	logic [SIDE_W-1:0]     rt_side;
	logic [2:0]            rt_zero;
	logic [2:0][2:0]       rt_neg;
	logic [2:0][2:0][31:0] rt_sh;

	assign rt_side_in = {side_s5, zero_s5, neg_s5, sh_s5};
	assign {rt_side, rt_zero, rt_neg, rt_sh} = rt_side_out;

	sarq_isqrt #(
		.LANES (3),
		.SIDE_W(RS_W)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.in_rad   (len_s5),
		.in_side  (rt_side_in),
		.out_valid(rt_valid),
		.out_root (rt_root),
		.out_side (rt_side_out)
	);

	logic [8:0][63:0]          dv_dividend;
	logic [8:0][31:0]          dv_divisor;
	logic                      dv_valid;
	logic [8:0][QUO_BITS-1:0]  dv_quot;
	logic [8:0]                dv_ovf;
	logic [DS_W-1:0]           dv_side_out;
	logic [SIDE_W-1:0]         dv_side;
	logic [2:0]                dv_zero;
	logic [2:0][2:0]           dv_neg;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int c = 0; c < 3; c++) begin
				dv_dividend[v*3+c] = {2'b00, rt_sh[v][c], 30'd0};
				dv_divisor[v*3+c]  = rt_root[v];
			end
		end
	end

	assign {dv_side, dv_zero, dv_neg} = dv_side_out;

	sarq_div #(
		.LANES (9),
		.SIDE_W(DS_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (rt_valid),
		.in_dividend(dv_dividend),
		.in_divisor (dv_divisor),
		.in_side    ({rt_side, rt_zero, rt_neg}),
		.out_valid  (dv_valid),
		.out_quot   (dv_quot),
		.out_ovf    (dv_ovf),
		.out_side   (dv_side_out)
	);

	logic [2:0][2:0][31:0] vec_s6;
	logic [SIDE_W-1:0]     side_s6;
	logic                  vld_s6;

	// The quotient never exceeds 2^30 here, so the overflow flag is unused
	// except for all-zero vectors, which are forced to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				for (int c = 0; c < 3; c++) begin
					if (dv_zero[v] || dv_ovf[v*3+c]) begin
						vec_s6[v][c] <= '0;
					end else if (dv_neg[v][c]) begin
						vec_s6[v][c] <= -32'(dv_quot[v*3+c]);
					end else begin
						vec_s6[v][c] <= 32'(dv_quot[v*3+c]);
					end
				end
			end
			side_s6 <= dv_side;
		end
	end

	assign out_valid = vld_s6;
	assign out_vec   = vec_s6;
	assign out_side  = side_s6;

endmodule

// File: rtl/shortest_arc_quaternion.sv
// Top level of the shortest-arc rotation quaternion pipeline.
// Takes a source vector and a destination vector (signed Q16.16) and a fallback
// axis (Q2.30), and returns the shortest-arc rotation quaternion between them in
// Q2.30 with a code for the case taken: identity, general arc, half turn about
// the fallback axis, or half turn about a generated axis. One transaction is
// accepted every clock cycle unless the output stalls. It is built from two
// 32-stage square-root and two 31-stage divider pipelines, one bit per stage,
// in series with the multiply and sum stages. The whole pipeline advances
// together: it holds only while a finished result waits at the output. The user
// must write the antiparallel limit register through cfg_wr_en and cfg_wr_data
// only while no transaction is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module shortest_arc_quaternion import sarq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIM_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] src_x,
	input  logic signed [31:0] src_y,
	input  logic signed [31:0] src_z,
	input  logic signed [31:0] dst_x,
	input  logic signed [31:0] dst_y,
	input  logic signed [31:0] dst_z,
	input  logic signed [31:0] fallback_x,
	input  logic signed [31:0] fallback_y,
	input  logic signed [31:0] fallback_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic [1:0]         case_taken
);

	localparam int RS_W = 1 + 1 + 96 + 3 + 192;
	localparam int DS_W = 1 + 1 + 96 + 3 + 1 + 32;

	logic             en;
	logic [LIM_W-1:0] limit_q;
	logic             out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Generated axis is X x src, or Y x src when that one is zero.
	logic              swap_axis;
	logic [2:0][2:0][32:0] nm_in;

	assign swap_axis = (src_y == '0) && (src_z == '0);

	always_comb begin
		nm_in[0][0] = {src_x[31], src_x};
		nm_in[0][1] = {src_y[31], src_y};
		nm_in[0][2] = {src_z[31], src_z};
		nm_in[1][0] = {dst_x[31], dst_x};
		nm_in[1][1] = {dst_y[31], dst_y};
		nm_in[1][2] = {dst_z[31], dst_z};
		nm_in[2][0] = '0;
		nm_in[2][1] = swap_axis ? 33'd0 : -{src_z[31], src_z};
		nm_in[2][2] = swap_axis ? -{src_x[31], src_x} : {src_y[31], src_y};
	end

	logic                  nm_valid;
	logic [2:0][2:0][31:0] nm_vec;
	logic [2:0][31:0]      nm_fb;

	sarq_norm #(
		.SIDE_W(96)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_vec   (nm_in),
		.in_side  ({fallback_z, fallback_y, fallback_x}),
		.out_valid(nm_valid),
		.out_vec  (nm_vec),
		.out_side (nm_fb)
	);

	// Products of the cross and dot terms, and the half-turn axis choice.
	logic signed [63:0] prod_s1 [9];
	logic [2:0][31:0]   alt_s1, alt_s2, alt_s3;
	logic               altfb_s1, altfb_s2, altfb_s3;
	logic               vld_s1, vld_s2, vld_s3;
	logic signed [63:0] cross_s2 [3];
	logic signed [63:0] dot_s2;
	logic [2:0][63:0]   cmag_s3;
	logic [2:0]         cneg_s3;
	logic               ident_s3;
	logic [63:0]        rad2_s3;
	logic signed [63:0] rad;
	logic               fb_nonzero;

	assign fb_nonzero = nm_fb != '0;
	assign rad        = ONE_Q60 + dot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= nm_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= $signed(nm_vec[0][1]) * $signed(nm_vec[1][2]);
			prod_s1[1] <= $signed(nm_vec[0][2]) * $signed(nm_vec[1][1]);
			prod_s1[2] <= $signed(nm_vec[0][2]) * $signed(nm_vec[1][0]);
			prod_s1[3] <= $signed(nm_vec[0][0]) * $signed(nm_vec[1][2]);
			prod_s1[4] <= $signed(nm_vec[0][0]) * $signed(nm_vec[1][1]);
			prod_s1[5] <= $signed(nm_vec[0][1]) * $signed(nm_vec[1][0]);
			prod_s1[6] <= $signed(nm_vec[0][0]) * $signed(nm_vec[1][0]);
			prod_s1[7] <= $signed(nm_vec[0][1]) * $signed(nm_vec[1][1]);
			prod_s1[8] <= $signed(nm_vec[0][2]) * $signed(nm_vec[1][2]);
			for (int c = 0; c < 3; c++) begin
				alt_s1[c] <= fb_nonzero ? sat_q30($signed(nm_fb[c])) : nm_vec[2][c];
			end
			altfb_s1 <= fb_nonzero;

			cross_s2[0] <= prod_s1[0] - prod_s1[1];
			cross_s2[1] <= prod_s1[2] - prod_s1[3];
			cross_s2[2] <= prod_s1[4] - prod_s1[5];
			dot_s2      <= prod_s1[6] + prod_s1[7] + prod_s1[8];
			alt_s2      <= alt_s1;
			altfb_s2    <= altfb_s1;

			for (int c = 0; c < 3; c++) begin
				cneg_s3[c] <= cross_s2[c] < 0;
				cmag_s3[c] <= cross_s2[c] < 0 ? 64'(-cross_s2[c]) : 64'(cross_s2[c]);
			end
			ident_s3 <= dot_s2 >= ONE_Q60;
			rad2_s3  <= rad > 0 ? 64'(rad) << 1 : 64'd0;
			alt_s3   <= alt_s2;
			altfb_s3 <= altfb_s2;
		end
	end

	logic              rt_valid;
	logic [0:0][31:0]  rt_root;
	logic [RS_W-1:0]   rt_side_out;
	logic              rt_ident, rt_altfb;
	logic [2:0][31:0]  rt_alt;
	logic [2:0]        rt_cneg;
	logic [2:0][63:0]  rt_cmag;

	assign {rt_ident, rt_altfb, rt_alt, rt_cneg, rt_cmag} = rt_side_out;

	sarq_isqrt #(
		.LANES (1),
		.SIDE_W(RS_W)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_rad   (rad2_s3),
		.in_side  ({ident_s3, altfb_s3, alt_s3, cneg_s3, cmag_s3}),
		.out_valid(rt_valid),
		.out_root (rt_root),
		.out_side (rt_side_out)
	);

	// A zero s always counts as opposite, so the divider never sees it on the
	// general path.
	logic              opposite;
	logic [2:0][31:0]  dv_divisor;
	logic              dv_valid;
	logic [2:0][QUO_BITS-1:0] dv_quot;
	logic [2:0]        dv_ovf;
	logic [DS_W-1:0]   dv_side_out;
	logic              dv_ident, dv_altfb, dv_opp;
	logic [2:0][31:0]  dv_alt;
	logic [2:0]        dv_cneg;
	logic [31:0]       dv_s;

	assign opposite   = (rt_root[0] == '0) || (rt_root[0] < 32'(limit_q));
	assign dv_divisor = {rt_root[0], rt_root[0], rt_root[0]};
	assign {dv_ident, dv_altfb, dv_alt, dv_cneg, dv_opp, dv_s} = dv_side_out;

	sarq_div #(
		.LANES (3),
		.SIDE_W(DS_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (rt_valid),
		.in_dividend(rt_cmag),
		.in_divisor (dv_divisor),
		.in_side    ({rt_ident, rt_altfb, rt_alt, rt_cneg, opposite, rt_root[0]}),
		.out_valid  (dv_valid),
		.out_quot   (dv_quot),
		.out_ovf    (dv_ovf),
		.out_side   (dv_side_out)
	);

	logic signed [31:0] arc_xyz [3];
	logic signed [31:0] arc_w;
	logic [30:0]        qmag [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qmag[c] = (dv_ovf[c] || dv_quot[c] > ONE_Q30_MAG) ? ONE_Q30_MAG : dv_quot[c];
			arc_xyz[c] = dv_cneg[c] ? -32'(qmag[c]) : 32'(qmag[c]);
		end
		arc_w = {1'b0, dv_s[31:1]};
	end

	logic signed [31:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	case_t              case_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_ident) begin
				quat_w_q <= ONE_Q30;
				quat_x_q <= '0;
				quat_y_q <= '0;
				quat_z_q <= '0;
				case_q   <= CASE_IDENTITY;
			end else if (dv_opp) begin
				quat_w_q <= '0;
				quat_x_q <= dv_alt[0];
				quat_y_q <= dv_alt[1];
				quat_z_q <= dv_alt[2];
				case_q   <= dv_altfb ? CASE_FALLBACK : CASE_GENERATED;
			end else begin
				quat_w_q <= arc_w;
				quat_x_q <= arc_xyz[0];
				quat_y_q <= arc_xyz[1];
				quat_z_q <= arc_xyz[2];
				case_q   <= CASE_ARC;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign quat_w     = quat_w_q;
	assign quat_x     = quat_x_q;
	assign quat_y     = quat_y_q;
	assign quat_z     = quat_z_q;
	assign case_taken = case_q;

	`SARQ_ASSERT(a_identity_value, clk, arst_n, (out_valid && case_taken == CASE_IDENTITY) |-> (quat_w == ONE_Q30 && quat_x == '0 && quat_y == '0 && quat_z == '0), "identity case carries a wrong quaternion")
	`SARQ_ASSERT(a_half_turn_w, clk, arst_n, (out_valid && (case_taken == CASE_FALLBACK || case_taken == CASE_GENERATED)) |-> (quat_w == '0), "half turn with nonzero scalar part")
	`SARQ_NEVER(a_out_range, clk, arst_n, out_valid && (quat_x > ONE_Q30 || quat_x < NEG_ONE_Q30 || quat_y > ONE_Q30 || quat_y < NEG_ONE_Q30 || quat_z > ONE_Q30 || quat_z < NEG_ONE_Q30 || quat_w > ONE_Q30 || quat_w < 0), "quaternion component outside its range")

endmodule
